FILE: rtl/mlpbp_pkg.sv
// Package for the 2-2-1 online backpropagation block: constants, codes,
// the microcode table and the sigmoid lookup table.
// No dependencies.
`timescale 1ns / 1ps

package mlpbp_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SIGMOID_ENTRIES = 256;
    localparam int TAB_BITS        = $clog2(SIGMOID_ENTRIES);
    localparam int RANGE_BITS      = FRAC_BITS + 3;
    localparam int REM_BITS        = RANGE_BITS - TAB_BITS;
    localparam int ACT_W           = FRAC_BITS + 1;
    localparam int W_W             = 24;
    localparam int NUM_WEIGHTS     = 9;
    localparam int STEP_W          = 5;
    localparam int FWD_LAST        = 8;
    localparam int TRAIN_LAST      = 25;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_INFER = 2'd0,
        KIND_TRAIN = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        A_W, A_TMP, A_LR, A_G, A_ERR2
    } asel_t;

    typedef enum logic [3:0] {
        B_X0, B_X1, B_H0, B_H1, B_Y, B_OMY, B_OMH0, B_OMH1, B_DOUT, B_DH0, B_DH1
    } bsel_t;

    // Writeback operations of one microcode step.
    typedef enum logic [3:0] {
        WB_ACC, WB_Z, WB_SIG_H0, WB_SIG_H1, WB_SIG_Y, WB_TMP,
        WB_DOUT, WB_DH0, WB_DH1, WB_G_W, WB_W
    } wb_t;

    typedef struct packed {
        asel_t      asel;
        logic [3:0] aidx;
        bsel_t      bsel;
        logic [3:0] didx;
        wb_t        wb;
    } ucode_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_RUN, ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_in;
        logic              rd_en;
        logic              mul_en;
        logic              wb_en;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic train;
    } dp_status_t;

    typedef logic [ACT_W-1:0] sig_tab_t [SIGMOID_ENTRIES + 1];

    // Step program: forward pass, then the gradient step.
    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t u;
        u = '{asel: A_W, aidx: 4'd0, bsel: B_X0, didx: 4'd0, wb: WB_ACC};
        case (step)
            5'd0:  u = '{A_W,   4'd0, B_X0,   4'd0, WB_ACC};
            5'd1:  u = '{A_W,   4'd1, B_X1,   4'd4, WB_Z};
            5'd2:  u = '{A_W,   4'd0, B_X0,   4'd0, WB_SIG_H0};
            5'd3:  u = '{A_W,   4'd2, B_X0,   4'd0, WB_ACC};
            5'd4:  u = '{A_W,   4'd3, B_X1,   4'd5, WB_Z};
            5'd5:  u = '{A_W,   4'd0, B_X0,   4'd0, WB_SIG_H1};
            5'd6:  u = '{A_W,   4'd6, B_H0,   4'd0, WB_ACC};
            5'd7:  u = '{A_W,   4'd7, B_H1,   4'd8, WB_Z};
            5'd8:  u = '{A_W,   4'd0, B_X0,   4'd0, WB_SIG_Y};
            5'd9:  u = '{A_ERR2, 4'd0, B_Y,   4'd0, WB_TMP};
            5'd10: u = '{A_TMP, 4'd0, B_OMY,  4'd0, WB_DOUT};
            5'd11: u = '{A_W,   4'd6, B_DOUT, 4'd0, WB_TMP};
            5'd12: u = '{A_TMP, 4'd0, B_H0,   4'd0, WB_TMP};
            5'd13: u = '{A_TMP, 4'd0, B_OMH0, 4'd0, WB_DH0};
            5'd14: u = '{A_W,   4'd7, B_DOUT, 4'd0, WB_TMP};
            5'd15: u = '{A_TMP, 4'd0, B_H1,   4'd0, WB_TMP};
            5'd16: u = '{A_TMP, 4'd0, B_OMH1, 4'd0, WB_DH1};
            5'd17: u = '{A_LR,  4'd0, B_DOUT, 4'd8, WB_G_W};
            5'd18: u = '{A_G,   4'd0, B_H0,   4'd6, WB_W};
            5'd19: u = '{A_G,   4'd0, B_H1,   4'd7, WB_W};
            5'd20: u = '{A_LR,  4'd0, B_DH0,  4'd4, WB_G_W};
            5'd21: u = '{A_G,   4'd0, B_X0,   4'd0, WB_W};
            5'd22: u = '{A_G,   4'd0, B_X1,   4'd1, WB_W};
            5'd23: u = '{A_LR,  4'd0, B_DH1,  4'd5, WB_G_W};
            5'd24: u = '{A_G,   4'd0, B_X0,   4'd2, WB_W};
            5'd25: u = '{A_G,   4'd0, B_X1,   4'd3, WB_W};
            default: u = '{A_W, 4'd0, B_X0,   4'd0, WB_ACC};
        endcase
        return u;
    endfunction

    // Shift-and-subtract quotient of two nonnegative values below 2^62.
    function automatic longint udiv(input longint num, input longint dvs);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--) begin
            r = (r <<< 1) | ((num >>> i) & longint'(1));
            q = q <<< 1;
            if (r >= dvs) begin
                r = r - dvs;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    // Sigmoid samples at k*8/SIGMOID_ENTRIES, rounded, built from a
    // Taylor series of exp(-u) in 30-bit fixed point at elaboration.
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t tab;
        longint   q30;
        longint   z;
        longint   e;
        longint   term;
        longint   sum;
        longint   den;
        q30 = longint'(1) <<< 30;
        for (int k = 0; k <= SIGMOID_ENTRIES; k++) begin
            z = (longint'(k) <<< 33) / SIGMOID_ENTRIES;
            term = q30;
            sum  = q30;
            for (int n = 1; n <= 24; n++) begin
                term = udiv((term * (z >>> 3)) >>> 30, longint'(n));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            e = sum;
            e = (e * e) >>> 30;
            e = (e * e) >>> 30;
            e = (e * e) >>> 30;
            den = q30 + e;
            tab[k] = ACT_W'(udiv((longint'(1) <<< (30 + FRAC_BITS)) + den / 2, den));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

FILE: rtl/mlpbp_ctrl.sv
// Controller for the 2-2-1 backpropagation block: sequences the
// microcode steps and owns the result valid flag. Depends on mlpbp_pkg.
`timescale 1ns / 1ps

module mlpbp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mlpbp_pkg::dp_status_t  status,
    output mlpbp_pkg::ctrl_cmd_t   cmd
);

    mlpbp_pkg::state_t                state_reg, state_next;
    logic [mlpbp_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [1:0]                       phase_reg, phase_next;
    logic                             mval_reg, mval_next;

    // State, step and phase registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlpbp_pkg::ST_IDLE;
            step_reg  <= '0;
            phase_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            mval_reg  <= mval_next;
        end
    end

    // Each step runs read, multiply and writeback phases.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        s_tready     = 1'b0;
        case (state_reg)
            mlpbp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    phase_next  = '0;
                    state_next  = mlpbp_pkg::ST_RUN;
                end
            end
            mlpbp_pkg::ST_RUN: begin
                case (phase_reg)
                    2'd0: begin
                        cmd.rd_en  = 1'b1;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        cmd.mul_en = 1'b1;
                        phase_next = 2'd2;
                    end
                    default: begin
                        cmd.wb_en  = 1'b1;
                        phase_next = 2'd0;
                        if ((step_reg == mlpbp_pkg::STEP_W'(mlpbp_pkg::FWD_LAST) &&
                             !status.train) ||
                            step_reg == mlpbp_pkg::STEP_W'(mlpbp_pkg::TRAIN_LAST)) begin
                            state_next = mlpbp_pkg::ST_FINISH;
                        end else begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                endcase
            end
            mlpbp_pkg::ST_FINISH: begin
                if (!mval_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = mlpbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlpbp_pkg::ST_IDLE;
            end
        endcase
    end

    // The result stays valid until the beat is taken.
    always_comb begin
        mval_next = mval_reg;
        if (cmd.out_load) begin
            mval_next = 1'b1;
        end else if (m_tready) begin
            mval_next = 1'b0;
        end
    end

    assign m_tvalid = mval_reg;

endmodule

FILE: rtl/mlpbp_datapath.sv
// Datapath for the 2-2-1 backpropagation block: weight store, one shared
// multiplier, sigmoid table unit and working registers. Depends on mlpbp_pkg.
`timescale 1ns / 1ps

module mlpbp_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [22:0]           cfg_wdata,
    input  logic [95:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    output logic [55:0]           m_tdata,
    input  mlpbp_pkg::ctrl_cmd_t  cmd,
    output mlpbp_pkg::dp_status_t status
);

    localparam int F = mlpbp_pkg::FRAC_BITS;
    localparam int AW = mlpbp_pkg::ACT_W;

    mlpbp_pkg::ucode_t u;

    logic [22:0]               lr_reg;
    mlpbp_pkg::kind_t          kind_reg;
    logic signed [23:0]        x0_reg, x1_reg, wv_reg;
    logic [16:0]               t_reg;
    logic [3:0]                widx_reg;
    logic signed [23:0]        mem [mlpbp_pkg::NUM_WEIGHTS];
    logic [mlpbp_pkg::NUM_WEIGHTS-1:0] wvalid_reg;
    logic signed [23:0]        rda_reg, rdd_reg;
    logic signed [63:0]        p_reg, acc_reg;
    logic signed [33:0]        z_reg;
    logic [AW-1:0]             h0_reg, h1_reg, y_reg;
    logic signed [31:0]        tmp_reg, dout_reg, dh0_reg, dh1_reg, g_reg;
    logic [55:0]               out_reg;

    logic signed [31:0]        a_op, b_op;
    logic signed [19:0]        err2;
    logic signed [63:0]        p_fl;
    logic signed [63:0]        zsum;
    logic signed [49:0]        wdiff;
    logic signed [23:0]        wsat;
    logic [AW-1:0]             sig_val;
    logic                      mem_we;
    logic [3:0]                mem_waddr;
    logic signed [23:0]        mem_wdata;

    assign u = mlpbp_pkg::ucode(cmd.step);
    assign status.train = (kind_reg == mlpbp_pkg::KIND_TRAIN);

    // Sigmoid by table with linear interpolation, odd-symmetric about 0.5.
    function automatic logic [AW-1:0] sigmoid(input logic signed [33:0] z);
        logic [33:0]                        a;
        logic [mlpbp_pkg::TAB_BITS:0]       idx;
        logic [mlpbp_pkg::REM_BITS-1:0]     rem;
        logic [AW-1:0]                      lo;
        logic [AW-1:0]                      hi;
        logic [AW+mlpbp_pkg::REM_BITS-1:0]  prod;
        logic [AW-1:0]                      val;
        a = z[33] ? 34'(-z) : 34'(z);
        idx = {1'b0, a[mlpbp_pkg::RANGE_BITS-1:mlpbp_pkg::REM_BITS]};
        rem = a[mlpbp_pkg::REM_BITS-1:0];
        lo = mlpbp_pkg::SIG_TAB[idx];
        hi = mlpbp_pkg::SIG_TAB[idx + 1'b1];
        prod = (AW + mlpbp_pkg::REM_BITS)'(hi - lo) * (AW + mlpbp_pkg::REM_BITS)'(rem);
        if (a >= (34'd1 << mlpbp_pkg::RANGE_BITS)) begin
            val = mlpbp_pkg::SIG_TAB[mlpbp_pkg::SIGMOID_ENTRIES];
        end else begin
            val = lo + AW'(prod >> mlpbp_pkg::REM_BITS);
        end
        return z[33] ? AW'((AW'(1) << F) - val) : val;
    endfunction

    // Learning rate register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= 23'(65536);
        end else if (cfg_we) begin
            lr_reg <= cfg_wdata;
        end
    end

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= mlpbp_pkg::KIND_INFER;
        end else if (cmd.load_in) begin
            kind_reg <= mlpbp_pkg::kind_t'(s_tuser);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x0_reg   <= s_tdata[23:0];
            x1_reg   <= s_tdata[47:24];
            t_reg    <= s_tdata[64:48];
            widx_reg <= s_tdata[68:65];
            wv_reg   <= s_tdata[92:69];
        end
    end

    // Multiplier operand selection.
    assign err2 = 20'(({3'b000, y_reg} - {3'b000, t_reg}) <<< 1);

    always_comb begin
        case (u.asel)
            mlpbp_pkg::A_W:    a_op = 32'(rda_reg);
            mlpbp_pkg::A_TMP:  a_op = tmp_reg;
            mlpbp_pkg::A_LR:   a_op = $signed({9'b0, lr_reg});
            mlpbp_pkg::A_G:    a_op = g_reg;
            mlpbp_pkg::A_ERR2: a_op = 32'(err2);
            default:           a_op = '0;
        endcase
        case (u.bsel)
            mlpbp_pkg::B_X0:   b_op = 32'(x0_reg);
            mlpbp_pkg::B_X1:   b_op = 32'(x1_reg);
            mlpbp_pkg::B_H0:   b_op = $signed({15'b0, h0_reg});
            mlpbp_pkg::B_H1:   b_op = $signed({15'b0, h1_reg});
            mlpbp_pkg::B_Y:    b_op = $signed({15'b0, y_reg});
            mlpbp_pkg::B_OMY:  b_op = (32'sd1 <<< F) - $signed({15'b0, y_reg});
            mlpbp_pkg::B_OMH0: b_op = (32'sd1 <<< F) - $signed({15'b0, h0_reg});
            mlpbp_pkg::B_OMH1: b_op = (32'sd1 <<< F) - $signed({15'b0, h1_reg});
            mlpbp_pkg::B_DOUT: b_op = dout_reg;
            mlpbp_pkg::B_DH0:  b_op = dh0_reg;
            mlpbp_pkg::B_DH1:  b_op = dh1_reg;
            default:           b_op = '0;
        endcase
    end

    // Floor shift of the product, of the two-product sum and the saturated update.
    assign p_fl    = p_reg >>> F;
    assign zsum    = (acc_reg + p_reg) >>> F;
    assign wdiff   = 50'(rdd_reg) - p_fl[49:0];
    assign sig_val = sigmoid(z_reg);

    always_comb begin
        if (wdiff > 50'sd8388607) begin
            wsat = 24'sd8388607;
        end else if (wdiff < -50'sd8388608) begin
            wsat = -24'sd8388608;
        end else begin
            wsat = wdiff[23:0];
        end
    end

    // Weight store port: update steps, or a weight write when the item ends.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = u.didx;
        mem_wdata = wsat;
        if (cmd.wb_en && (u.wb == mlpbp_pkg::WB_G_W || u.wb == mlpbp_pkg::WB_W)) begin
            mem_we = 1'b1;
        end else if (cmd.out_load && kind_reg == mlpbp_pkg::KIND_WRITE &&
                     widx_reg < 4'(mlpbp_pkg::NUM_WEIGHTS)) begin
            mem_we    = 1'b1;
            mem_waddr = widx_reg;
            mem_wdata = wv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
        end else if (mem_we) begin
            wvalid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rda_reg <= wvalid_reg[u.aidx] ? mem[u.aidx] : '0;
            rdd_reg <= wvalid_reg[u.didx] ? mem[u.didx] : '0;
        end
    end

    // Shared multiplier.
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            p_reg <= a_op * b_op;
        end
    end

    // Writeback of the step result.
    always_ff @(posedge aclk) begin
        if (cmd.wb_en) begin
            case (u.wb)
                mlpbp_pkg::WB_ACC:    acc_reg  <= p_reg;
                mlpbp_pkg::WB_Z:      z_reg    <= 34'(rdd_reg) + zsum[33:0];
                mlpbp_pkg::WB_SIG_H0: h0_reg   <= sig_val;
                mlpbp_pkg::WB_SIG_H1: h1_reg   <= sig_val;
                mlpbp_pkg::WB_SIG_Y:  y_reg    <= sig_val;
                mlpbp_pkg::WB_TMP:    tmp_reg  <= p_fl[31:0];
                mlpbp_pkg::WB_DOUT:   dout_reg <= p_fl[31:0];
                mlpbp_pkg::WB_DH0:    dh0_reg  <= p_fl[31:0];
                mlpbp_pkg::WB_DH1:    dh1_reg  <= p_fl[31:0];
                mlpbp_pkg::WB_G_W:    g_reg    <= p_fl[31:0];
                default: begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= {5'b0, y_reg, h1_reg, h0_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

FILE: rtl/mlp_online_backprop_step_top.sv
// Top level of the 2-2-1 sigmoid network with online gradient steps.
// Depends on mlpbp_pkg, mlpbp_ctrl and mlpbp_datapath.
//
// Channel | Direction | Ports
// config  | in        | cfg_we, cfg_wdata (learn_rate)
// input   | in        | s_tvalid, s_tready, s_tdata, s_tuser
// result  | out       | m_tvalid, m_tready, m_tdata
//
// Every microcode step runs a weight read, a multiply and a writeback in
// turn on the one shared multiplier. Infer and write beats run nine
// steps from accept to result; a train beat runs 26 steps. Reset is
// synchronous and clears the weights to zero through valid bits at once.
// A stalled result holds in the output register; the next beat is
// accepted while it waits.
`timescale 1ns / 1ps

module mlp_online_backprop_step_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [22:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_first[23:0], x_second[47:24], target[64:48], weight_index[68:65],
    // weight_value[92:69], zero fill[95:93]
    input  logic [95:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hidden_zero[16:0], hidden_one[33:17], net_output[50:34], zero fill[55:51]
    output logic [55:0] m_tdata
);

    mlpbp_pkg::ctrl_cmd_t  cmd;
    mlpbp_pkg::dp_status_t status;

    mlpbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlpbp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // An accepted beat keeps the block busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A new result appears whenever an item completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result not presented after item completion");

    // The result register is never reloaded while a beat is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.out_load)
        else $error("stalled result overwritten");

endmodule
